// ===== rtl/ksm_pkg.sv =====
// package for the keyword span marker: sizes, command codes and transaction types
// used by every module of the block; depends on nothing
package ksm_pkg;

    localparam int MAX_WORDS = 64;
    localparam int MAX_LEN   = 16;

    localparam int SLOT_W = 6;
    localparam int POS_W  = 4;
    localparam int LEN_W  = 5;
    localparam int CHAR_W = 8;

    localparam logic CMD_KEYWORD = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef logic [MAX_LEN-1:0][CHAR_W-1:0] win_t;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  keyword_length;
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              marked;
        logic              open_before;
        logic              close_after;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
    } kw_wr_t;

endpackage

// ===== rtl/ksm_kw_mem.sv =====
// keyword table: one row of characters per slot plus the slot lengths
// depends on ksm_pkg
module ksm_kw_mem
    import ksm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  kw_wr_t            wr,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    output win_t              rd_row,
    output logic [LEN_W-1:0]  rd_len
);

    win_t                 kw_row_mem [MAX_WORDS];
    logic [LEN_W-1:0]     len_mem    [MAX_WORDS];
    logic [MAX_WORDS-1:0] len_vld_reg;
    win_t                 rd_row_reg;
    logic [LEN_W-1:0]     rd_len_reg;
    logic                 rd_vld_reg;

    // byte-lane write into the slot row
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            kw_row_mem[wr.slot][wr.pos] <= wr.ch;
            len_mem[wr.slot]            <= wr.len;
        end
        if (rd_en) begin
            rd_row_reg <= kw_row_mem[rd_slot];
            rd_len_reg <= len_mem[rd_slot];
        end
    end

    // unwritten slots read as length zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                len_vld_reg[wr.slot] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= len_vld_reg[rd_slot];
            end
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_len = rd_vld_reg ? rd_len_reg : '0;

endmodule

// ===== rtl/ksm_match_unit.sv =====
// shared compare unit: one keyword row against the recent-character window
// depends on ksm_pkg
module ksm_match_unit
    import ksm_pkg::*;
(
    input  logic               valid,
    input  win_t               row,
    input  logic [LEN_W-1:0]   len,
    input  win_t               window,
    input  logic [LEN_W-1:0]   count,
    output logic [MAX_LEN-1:0] mask
);

    logic             hit;
    logic [POS_W-1:0] len_m1;
    logic [POS_W-1:0] idx;

    always_comb begin
        len_m1 = len[POS_W-1:0] - 1'b1;
        idx    = '0;
        hit    = valid && (len != '0) && (len < LEN_W'(MAX_LEN)) && (len <= count);
        // keyword char p lines up with window entry len-1-p
        for (int p = 0; p < MAX_LEN; p++) begin
            idx = len_m1 - POS_W'(p);
            if ((LEN_W'(p) < len) && (row[p] != window[idx])) begin
                hit = 1'b0;
            end
        end
        for (int p = 0; p < MAX_LEN; p++) begin
            mask[p] = hit && (LEN_W'(p) < len);
        end
    end

endmodule

// ===== rtl/keyword_span_marker_unit.sv =====
// top level of the keyword span marker: sequencer, character window, result register
// depends on ksm_pkg, ksm_kw_mem and ksm_match_unit
//
// usage
//   s_ channel takes one transaction per item. cmd = keyword writes one
//   character and the length of a slot into the keyword table; cmd = text
//   pushes one character into a window of the last MAX_LEN characters.
//   m_ channel delivers one transaction per character that leaves the window,
//   with its mark and the open/close tag flags.
// timing
//   a keyword transaction goes into the table and leaves the unit idle. a
//   text transaction runs the slot scan, where the shared compare unit
//   checks one keyword slot per cycle against the window, reading one
//   table row per cycle, then a drain step, then the results one by one:
//   none or one normally, up to MAX_LEN on end of text. s_ready is low until then.
// reset
//   aresetn clears the marks, the count and all slot lengths; the window
//   and keyword characters stay undefined until written.
// stall
//   results sit in an output register; a low m_ready holds the scan's
//   result sequence, and the next input is taken while the last result waits
module keyword_span_marker_unit
    import ksm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]         state_reg,    state_next;
    logic [SLOT_W-1:0]  slot_cnt_reg, slot_cnt_next;
    logic               rd_pend_reg,  rd_pend_next;
    win_t               win_reg,      win_next;
    logic [MAX_LEN-1:0] marks_reg,    marks_next;
    logic [LEN_W-1:0]   count_reg,    count_next;
    logic               prev_reg,     prev_next;
    logic               eot_reg,      eot_next;
    logic [POS_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               m_valid_reg,  m_valid_next;
    out_item_t          m_item_reg,   m_item_next;

    logic               accept;
    kw_wr_t             kw_wr;
    logic               rd_en;
    win_t               rd_row;
    logic [LEN_W-1:0]   rd_len;
    logic [MAX_LEN-1:0] hit_mask;
    logic               out_free;
    logic               cur_mark;
    logic               nxt_mark;
    logic [LEN_W-1:0]   cnt_m1;
    logic [POS_W-1:0]   idx_m1;
    out_item_t          new_item;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // keyword transactions go straight into the table
    assign kw_wr.en   = accept && (s_item.cmd == CMD_KEYWORD);
    assign kw_wr.slot = s_item.slot;
    assign kw_wr.pos  = s_item.position;
    assign kw_wr.ch   = s_item.char_code;
    assign kw_wr.len  = s_item.keyword_length;

    // one slot read per cycle during the scan
    assign rd_en = (state_reg == ST_MATCH);

    ksm_kw_mem u_kw_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (kw_wr),
        .rd_en   (rd_en),
        .rd_slot (slot_cnt_reg),
        .rd_row  (rd_row),
        .rd_len  (rd_len)
    );

    ksm_match_unit u_match (
        .valid  (rd_pend_reg),
        .row    (rd_row),
        .len    (rd_len),
        .window (win_reg),
        .count  (count_reg),
        .mask   (hit_mask)
    );

    // fields of the character being emitted
    assign out_free = !m_valid_reg || m_ready;
    assign idx_m1   = emit_idx_reg - 1'b1;
    assign cur_mark = marks_reg[emit_idx_reg];
    assign nxt_mark = (emit_idx_reg != '0) ? marks_reg[idx_m1] : 1'b0;
    assign cnt_m1   = count_reg - 1'b1;

    always_comb begin
        new_item.out_char    = win_reg[emit_idx_reg];
        new_item.marked      = cur_mark;
        new_item.open_before = cur_mark && !prev_reg;
        new_item.close_after = cur_mark && !nxt_mark;
        new_item.last        = eot_reg && (emit_idx_reg == '0);
    end

    always_comb begin
        state_next    = state_reg;
        slot_cnt_next = slot_cnt_reg;
        rd_pend_next  = rd_en;
        win_next      = win_reg;
        marks_next    = marks_reg;
        count_next    = count_reg;
        prev_next     = prev_reg;
        eot_next      = eot_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;

        // registered read lands in the cycle after the address
        if (rd_pend_reg) begin
            marks_next = marks_reg | hit_mask;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_item.cmd == CMD_TEXT)) begin
                    win_next   = {win_reg[MAX_LEN-2:0], s_item.char_code};
                    marks_next = {marks_reg[MAX_LEN-2:0], 1'b0};
                    if (count_reg < LEN_W'(MAX_LEN)) begin
                        count_next = count_reg + 1'b1;
                    end
                    eot_next      = s_item.end_of_text;
                    slot_cnt_next = '0;
                    state_next    = ST_MATCH;
                end
            end
            ST_MATCH: begin
                slot_cnt_next = slot_cnt_reg + 1'b1;
                if (slot_cnt_reg == SLOT_W'(MAX_WORDS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // decide how many characters leave
                if (eot_reg) begin
                    emit_idx_next = cnt_m1[POS_W-1:0];
                    state_next    = ST_EMIT;
                end else if (count_reg == LEN_W'(MAX_LEN)) begin
                    emit_idx_next = POS_W'(MAX_LEN - 1);
                    state_next    = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = new_item;
                    prev_next    = cur_mark;
                    if (eot_reg && (emit_idx_reg != '0)) begin
                        emit_idx_next = idx_m1;
                    end else begin
                        state_next = ST_IDLE;
                        if (eot_reg) begin
                            // flush done: start a fresh text
                            win_next   = '0;
                            marks_next = '0;
                            count_next = '0;
                            prev_next  = 1'b0;
                        end else begin
                            count_next = LEN_W'(MAX_LEN - 1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            marks_reg    <= '0;
            count_reg    <= '0;
            prev_reg     <= 1'b0;
            eot_reg      <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_cnt_reg <= slot_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            marks_reg    <= marks_next;
            count_reg    <= count_next;
            prev_reg     <= prev_next;
            eot_reg      <= eot_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // pending count never exceeds the window
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LEN_W'(MAX_LEN))
        else $error("pending count beyond window");

    // a text transaction always starts a slot scan from slot zero
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_item.cmd == CMD_TEXT)) |=>
            ((state_reg == ST_MATCH) && (slot_cnt_reg == '0)))
        else $error("slot scan did not start");

    // tag flags only on marked characters
    a_tag_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.marked || (!m_item.open_before && !m_item.close_after)))
        else $error("tag flag on unmarked character");

    // the final character of a text leaves the window empty
    a_flush_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free && new_item.last) |=>
            ((count_reg == '0) && (marks_reg == '0) && (state_reg == ST_IDLE)))
        else $error("window not cleared after end of text");

endmodule
